/* hw/rtl/lis_pkg.sv */
// ----------------------------------------------------------------------------
// lis_pkg: shared types and constants for the increasing-run tracker
// Table size, field widths, the item and result structs and the token that travels between the cells.
// ----------------------------------------------------------------------------
package lis_pkg;

	// Table size and value width
	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_BITS  = 20;

	// Internal length width: must hold TABLE_DEPTH itself
	localparam int LEN_W     = $clog2(TABLE_DEPTH + 1);
	// Length width on the result port
	localparam int OUT_LEN_W = 11;

	// Input item
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  first_of_sequence;
	} lis_in_t;

	// Result item
	typedef struct packed {
		logic [OUT_LEN_W-1:0] ending_length;
		logic [OUT_LEN_W-1:0] best_length;
		logic                 overflow;
	} lis_out_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  first;   // clear every cell on the way
		logic                  placed;  // value already written into a cell
		logic [LEN_W-1:0]      ending;  // cells visited until placed
	} lis_tok_t;

endpackage

/* hw/rtl/lis_cell.sv */
// ----------------------------------------------------------------------------
// lis_cell: one tail slot of the row
// Holds one tail value and its in-use flag. A passing token either lands here
// (first slot not below its value, or first free slot) or moves on.
// ----------------------------------------------------------------------------
module lis_cell
	import lis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  lis_tok_t in_tok,
	output logic     out_valid,
	output lis_tok_t out_tok
);

	logic                  used_q;
	logic                  vld_q;
	logic [VALUE_BITS-1:0] tail_q;
	lis_tok_t              tok_q;

	logic     used_eff;
	logic     hit;
	lis_tok_t tok_d;

	// Slot match: a start token sees the slot as empty
	always_comb begin
		used_eff = used_q && !in_tok.first;
		hit      = !in_tok.placed && (!used_eff || (tail_q >= in_tok.value));
		tok_d        = in_tok;
		tok_d.placed = in_tok.placed || hit;
		tok_d.ending = in_tok.placed ? in_tok.ending : in_tok.ending + LEN_W'(1);
	end

	// Control: in-use flag and token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
			if (in_valid) begin
				if (in_tok.first) begin
					used_q <= hit;
				end else if (hit) begin
					used_q <= 1'b1;
				end
			end
		end
	end

	// Payload: tail value and forwarded token
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			if (hit) begin
				tail_q <= in_tok.value;
			end
			tok_q <= tok_d;
		end
	end

	assign out_valid = vld_q;
	assign out_tok   = tok_q;

endmodule

/* hw/rtl/longest_increasing_subsequence_stream.sv */
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_stream: streaming longest increasing run
// Patience-sorting tail table built as a row of cells; each value ripples
// down the row and lands in the first tail not below it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  item     | in        | item_valid / item_stall   | lis_in_t  (value, start flag)
//  result   | out       | result_valid / result_stall | lis_out_t (lengths, overflow)
//
//  One item enters per cycle unless item_stall is high; each result leaves
//  after its token has passed through every cell of the row and the result register.
//  Reset clears the in-use flags, the row token valids and the run length;
//  no clearing pass is needed.
//  A held result freezes the whole row and stalls the item side.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_stream
	import lis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  lis_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output lis_out_t result
);

	logic     adv;
	logic     tok_valid [0:TABLE_DEPTH];
	lis_tok_t tok       [0:TABLE_DEPTH];

	logic             res_valid_q;
	lis_out_t         res_q;
	logic [LEN_W-1:0] run_q;

	logic             last_valid;
	lis_tok_t         last_tok;
	logic [LEN_W-1:0] best_d;

	// Row advances unless a result is held
	assign adv        = !res_valid_q || !result_stall;
	assign item_stall = !adv;

	// Token entering the first cell
	assign tok_valid[0] = item_valid;
	assign tok[0]       = '{value:  item.value,
	                        first:  item.first_of_sequence,
	                        placed: 1'b0,
	                        ending: '0};

	// Row of tail cells
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		lis_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (tok_valid[k]),
			.in_tok    (tok[k]),
			.out_valid (tok_valid[k+1]),
			.out_tok   (tok[k+1])
		);
	end

	assign last_valid = tok_valid[TABLE_DEPTH];
	assign last_tok   = tok[TABLE_DEPTH];

	// Best length: restarts on a start token, else the larger of run and ending
	always_comb begin
		if (last_tok.first) begin
			best_d = last_tok.ending;
		end else if (run_q > last_tok.ending) begin
			best_d = run_q;
		end else begin
			best_d = last_tok.ending;
		end
	end

	// Control: result valid and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			run_q       <= '0;
		end else if (adv) begin
			res_valid_q <= last_valid;
			if (last_valid) begin
				run_q <= best_d;
			end
		end
	end

	// Result payload; an unplaced token has visited every cell
	always_ff @(posedge clk) begin
		if (adv && last_valid) begin
			res_q.ending_length <= OUT_LEN_W'(last_tok.ending);
			res_q.best_length   <= OUT_LEN_W'(best_d);
			res_q.overflow      <= !last_tok.placed;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Checks
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.ending_length != '0))
		else $error("result with zero ending length");

	a_end_le_best: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.ending_length <= result.best_length))
		else $error("ending length above best length");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |->
			((result.ending_length == OUT_LEN_W'(TABLE_DEPTH)) &&
			 (result.best_length == OUT_LEN_W'(TABLE_DEPTH))))
		else $error("overflow without saturated lengths");

	a_unplaced_end: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && !last_tok.placed) |-> (last_tok.ending == LEN_W'(TABLE_DEPTH)))
		else $error("unplaced token left the row early");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && adv) |=> (run_q <= LEN_W'(TABLE_DEPTH)))
		else $error("run length beyond table depth");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for longest_increasing_subsequence_stream
// Drives value transfers with random gaps and checks every result transfer against a
// tail-table model kept alongside or a directed row's typed result. A short directed
// list comes first, then random sequences, one of them long enough to fill the table.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lis_pkg::*;

	localparam int VALUE_MAX    = (1 << VALUE_BITS) - 1;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 4000;
	localparam int HOLD_AFTER   = 400;
	localparam int REPORT_LIMIT = 50;

	// Shape of the values in one random sequence
	typedef enum int {PAT_WIDE, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_NOISE} value_pattern_t;

	// One directed row: stimulus, and the result when it is obvious
	typedef struct packed {
		lis_in_t  stim;
		logic     typed;
		lis_out_t want;
	} directed_row_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	lis_in_t  item         = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	lis_out_t result;

	// Model state: smallest tail per run length, and the count in use
	logic [VALUE_BITS-1:0] tail_tab [TABLE_DEPTH];
	int                    run_len = 0;

	lis_out_t pending_results [$];
	lis_out_t oldest_result;
	int       mismatches     = 0;
	int       accepted_items = 0;
	int       tx_burst       = 0;
	int       rx_burst       = 0;

	// Directed rows: extremes, equal values, start flag, alternating bits
	directed_row_t directed_rows [24] = '{
		'{'{20'h00000, 1'b1}, 1'b1, '{11'd1, 11'd1, 1'b0}},  // start after reset
		'{'{20'hFFFFF, 1'b0}, 1'b1, '{11'd2, 11'd2, 1'b0}},  // largest value grows
		'{'{20'hFFFFF, 1'b0}, 1'b1, '{11'd2, 11'd2, 1'b0}},  // equal to top tail
		'{'{20'h00000, 1'b0}, 1'b1, '{11'd1, 11'd2, 1'b0}},  // equal to bottom tail
		'{'{20'h80000, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'h80001, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'h7FFFF, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'hFFFFF, 1'b1}, 1'b1, '{11'd1, 11'd1, 1'b0}},  // start on largest
		'{'{20'h00000, 1'b0}, 1'b1, '{11'd1, 11'd1, 1'b0}},
		'{'{20'h00001, 1'b0}, 1'b1, '{11'd2, 11'd2, 1'b0}},
		'{'{20'h00002, 1'b0}, 1'b1, '{11'd3, 11'd3, 1'b0}},
		'{'{20'h00003, 1'b0}, 1'b1, '{11'd4, 11'd4, 1'b0}},
		'{'{20'h00001, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'h00000, 1'b1}, 1'b1, '{11'd1, 11'd1, 1'b0}},
		'{'{20'h00000, 1'b0}, 1'b1, '{11'd1, 11'd1, 1'b0}},  // repeated zero
		'{'{20'h00000, 1'b0}, 1'b1, '{11'd1, 11'd1, 1'b0}},
		'{'{20'hAAAAA, 1'b1}, 1'b1, '{11'd1, 11'd1, 1'b0}},
		'{'{20'h55555, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'hAAAAA, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'hFFFFE, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'hFFFFF, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'h80000, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}},
		'{'{20'h00001, 1'b1}, 1'b1, '{11'd1, 11'd1, 1'b0}},
		'{'{20'hFFFFF, 1'b0}, 1'b0, '{11'd0, 11'd0, 1'b0}}
	};

	longest_increasing_subsequence_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Gap length: mostly none or short, a few long, now and then a burst with none
	function automatic int idle_cycles(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 120);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// Lower-bound search over the tails, then overwrite, grow or saturate
	function automatic lis_out_t advance_tails(input lis_in_t it);
		int       lo;
		int       hi;
		int       mid;
		int       ending;
		lis_out_t res;
		res = '0;
		if (it.first_of_sequence)
			run_len = 0;
		lo = 0;
		hi = run_len;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (tail_tab[mid] < it.value)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < run_len) begin
			tail_tab[lo] = it.value;
			ending = lo + 1;
		end else if (run_len < TABLE_DEPTH) begin
			tail_tab[run_len] = it.value;
			run_len++;
			ending = run_len;
		end else begin
			res.overflow = 1'b1;
			ending = TABLE_DEPTH;
		end
		res.ending_length = ending[OUT_LEN_W-1:0];
		res.best_length   = run_len[OUT_LEN_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Offer one value transfer after a random gap; entered and left at a falling edge
	task automatic offer_item(input lis_in_t it, input logic use_typed, input lis_out_t typed);
		int          gap;
		logic [31:0] junk;
		lis_out_t    predicted;
		gap = idle_cycles(tx_burst);
		if (gap > 0) begin
			junk = $urandom;
			item_valid <= 1'b0;
			item       <= junk[$bits(lis_in_t)-1:0];
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = advance_tails(it);
		pending_results.push_back(use_typed ? typed : predicted);
		accepted_items++;
		@(negedge clk);
	endtask

	// Result side: compare each transfer with the oldest pending result
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", result.best_length, 0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (result.ending_length != oldest_result.ending_length)
					report_mismatch("ending_length", result.ending_length,
						oldest_result.ending_length);
				if (result.best_length != oldest_result.best_length)
					report_mismatch("best_length", result.best_length,
						oldest_result.best_length);
				if (result.overflow != oldest_result.overflow)
					report_mismatch("overflow", result.overflow, oldest_result.overflow);
			end
		end
	end

	// Result stall: random gaps, plus one long hold so the row fills up
	initial begin : result_side
		int   n;
		logic held_off;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && accepted_items >= HOLD_AFTER) begin
				held_off = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
			end else begin
				n = idle_cycles(rx_burst);
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	// Stimulus: directed rows, then random sequences
	initial begin : item_side
		int             k;
		int             r;
		int             seq_len;
		int             v;
		int             ramp;
		int             random_sent;
		logic           long_run_done;
		value_pattern_t pat;
		lis_in_t        it;
		lis_out_t       none;
		none          = '0;
		random_sent   = 0;
		long_run_done = 1'b0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < $size(directed_rows); k++)
			offer_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

		// pause until every pending result has come back
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);

		while (random_sent < RANDOM_ITEMS) begin
			if (!long_run_done && random_sent >= 150) begin
				// one run past the table depth: mostly rising, a few dips and repeats
				item_valid <= 1'b0;
				@(negedge clk);
				while (pending_results.size() != 0)
					@(negedge clk);
				ramp    = $urandom_range(0, 1000);
				seq_len = TABLE_DEPTH + 96;
				for (k = 0; k < seq_len; k++) begin
					r = $urandom_range(0, 63);
					if (r == 0) begin
						v = $urandom_range(0, ramp);
					end else if (r < 3) begin
						v = ramp;
					end else begin
						ramp = ramp + $urandom_range(1, 800);
						v    = ramp;
					end
					it.value             = VALUE_BITS'(v);
					it.first_of_sequence = (k == 0);
					offer_item(it, 1'b0, none);
				end
				random_sent  += seq_len;
				long_run_done = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0:       pat = PAT_NOISE;
					1, 2, 3: pat = PAT_WIDE;
					4, 5:    pat = PAT_NARROW;
					6, 7:    pat = PAT_RISING;
					default: pat = PAT_FALLING;
				endcase
				seq_len = $urandom_range(1, 40);
				ramp    = (pat == PAT_FALLING) ? $urandom_range(VALUE_MAX / 2, VALUE_MAX)
				                               : $urandom_range(0, VALUE_MAX / 2);
				for (k = 0; k < seq_len; k++) begin
					case (pat)
						PAT_NARROW: begin
							v = ($urandom_range(0, 1) ? VALUE_MAX - 15 : 0) + $urandom_range(0, 15);
						end
						PAT_RISING: begin
							ramp = ramp + $urandom_range(0, 4000);
							if (ramp > VALUE_MAX)
								ramp = VALUE_MAX;
							v = ramp;
						end
						PAT_FALLING: begin
							ramp = ramp - $urandom_range(0, 4000);
							if (ramp < 0)
								ramp = 0;
							v = ramp;
						end
						default: v = $urandom_range(0, VALUE_MAX);
					endcase
					it.value = VALUE_BITS'(v);
					// noise flips the start flag at random; now and then a sequence
					// carries on from the previous one without a start
					if (pat == PAT_NOISE)
						it.first_of_sequence = 1'($urandom_range(0, 1));
					else
						it.first_of_sequence = (k == 0) && ($urandom_range(0, 7) != 0);
					offer_item(it, 1'b0, none);
				end
				random_sent += seq_len;
			end
		end

		// drain, then allow a full row latency for stray results
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (TABLE_DEPTH + 64) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
